// ===== rtl/assert_macros.svh =====
// Assertion macros used by mesh_edge_length_ratio_core, the top level of the edge length ratio block.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/mler_pkg.sv =====
// Package of the mesh edge length ratio block: constants, edge tables, types.
// Used by mesh_edge_length_ratio_core and its testbench; depends on nothing.
package mler_pkg;

	localparam int MAX_VERTICES    = 8;
	localparam int COORD_WIDTH     = 32;
	localparam int RATIO_FRAC_BITS = 16;

	localparam int STORE_W  = 32;
	localparam int VERT_W   = 3 * STORE_W;
	localparam int VIDX_W   = $clog2(MAX_VERTICES);
	localparam int CNT_W    = 4;
	localparam int TYPE_W   = 3;
	localparam int RATIO_W  = RATIO_FRAC_BITS + 1;
	localparam int QUOT_W   = 2 * RATIO_FRAC_BITS + 1;
	localparam int PROD_W   = 2 * STORE_W;
	localparam int SQ_W     = PROD_W + 2;
	localparam int REM_W    = SQ_W + 1;
	localparam int STEP_W   = $clog2(QUOT_W);
	localparam int BIT_W    = $clog2(RATIO_W);
	localparam int NUM_EDGE_ENTRIES = 34;
	localparam int EIDX_W   = $clog2(NUM_EDGE_ENTRIES);

	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << RATIO_FRAC_BITS;

	localparam logic [TYPE_W-1:0] ET_EDGE     = 3'd0;
	localparam logic [TYPE_W-1:0] ET_TRIANGLE = 3'd1;
	localparam logic [TYPE_W-1:0] ET_QUAD     = 3'd2;
	localparam logic [TYPE_W-1:0] ET_TETRA    = 3'd3;
	localparam logic [TYPE_W-1:0] ET_PRISM    = 3'd4;
	localparam logic [TYPE_W-1:0] ET_HEX      = 3'd5;
	localparam logic [TYPE_W-1:0] ET_FIRST_NS = 3'd6;
	localparam logic [TYPE_W-1:0] ET_LAST_NS  = 3'd7;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_BAD_TYPE  = 2'd1;
	localparam logic [1:0] STS_BAD_COUNT = 2'd2;
	localparam logic [1:0] STS_ZERO_EDGE = 2'd3;

	localparam logic [VIDX_W-1:0] EDGE_A [NUM_EDGE_ENTRIES] = '{
		3'd0, 3'd1, 3'd0,
		3'd0, 3'd1, 3'd2, 3'd3,
		3'd0, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
	localparam logic [VIDX_W-1:0] EDGE_B [NUM_EDGE_ENTRIES] = '{
		3'd1, 3'd2, 3'd2,
		3'd1, 3'd2, 3'd3, 3'd0,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
		3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3, 3'd3, 3'd4, 3'd5,
		3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

	localparam logic [EIDX_W-1:0] TYPE_FIRST [8] = '{
		6'd0, 6'd0, 6'd3, 6'd7, 6'd13, 6'd22, 6'd0, 6'd0};
	localparam logic [CNT_W-1:0] TYPE_EDGES [8] = '{
		4'd0, 4'd3, 4'd4, 4'd6, 4'd9, 4'd12, 4'd0, 4'd0};
	localparam logic [CNT_W-1:0] TYPE_VERTS [8] = '{
		4'd2, 4'd3, 4'd4, 4'd4, 4'd6, 4'd8, 4'd0, 4'd0};

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_DIFF, S_SQ, S_ADD, S_CMP,
		S_HCHK, S_DIV, S_SQM, S_SQC, S_FIN
	} state_t;

	typedef struct packed {
		logic [TYPE_W-1:0]  elem_type;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} item_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [1:0]         status;
	} result_t;

endpackage

// ===== rtl/mler_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the vertex coordinates of the open element; no dependencies.
module mler_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mesh_edge_length_ratio_core.sv =====
// Top level of the mesh edge length ratio block: sequencer, shared multiplier,
// divider and square root steps. Depends on mler_pkg, mler_ram, assert_macros.svh.
//
// Channel | Direction | Handshake            | Payload
// item    | in        | item_valid/item_stall | mler_pkg::item_t, one vertex
// result  | out       | result_valid/result_stall | mler_pkg::result_t
//
// A vertex that does not close an element is taken in the idle state, which the block keeps.
// A closing vertex with an error or of an edge element goes straight to the final state.
// Otherwise a closing vertex has each edge read, differenced, squared and compared in turn, then
// the zero check, division and square root, all on one 32 by 32 multiplier and one
// subtractor; with a zero longest edge the division and square root are skipped.
// Reset clears the control state; the vertex memory needs no clearing.
// A new result waits in the final state while the previous one is still stalled.
`include "assert_macros.svh"

module mesh_edge_length_ratio_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  mler_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output mler_pkg::result_t  result
);

	mler_pkg::state_t state_q, state_d;

	logic [mler_pkg::CNT_W-1:0]   cnt_q;
	logic [mler_pkg::TYPE_W-1:0]  type_q;
	logic [mler_pkg::EIDX_W-1:0]  eidx_q;
	logic [mler_pkg::CNT_W-1:0]   ecnt_q;
	logic [1:0]                   k_q;
	logic [mler_pkg::VERT_W-1:0]  va_q;
	logic [mler_pkg::STORE_W-1:0] d_q [3];
	logic [mler_pkg::PROD_W-1:0]  prod_q;
	logic [mler_pkg::SQ_W-1:0]    acc_q, lo_q, hi_q;
	logic [mler_pkg::REM_W-1:0]   rem_q;
	logic [mler_pkg::QUOT_W-1:0]  quot_q;
	logic [mler_pkg::STEP_W-1:0]  step_q;
	logic [mler_pkg::RATIO_W-1:0] r_q;
	logic [mler_pkg::BIT_W-1:0]   bit_q;
	mler_pkg::result_t            res_q;
	mler_pkg::result_t            out_q;
	logic                         out_valid_q;

	logic                           accept;
	logic [mler_pkg::TYPE_W-1:0]    cur_t;
	logic [mler_pkg::CNT_W-1:0]     cnt_inc;
	logic                           bad_type, bad_count, quick;
	logic                           we;
	logic [mler_pkg::VIDX_W-1:0]    raddr;
	logic [mler_pkg::VERT_W-1:0]    rdata, wdata;
	logic [mler_pkg::STORE_W-1:0]   dcomb [3];
	logic [mler_pkg::STORE_W-1:0]   mul_a;
	logic [mler_pkg::PROD_W-1:0]    mul_res;
	logic [mler_pkg::RATIO_W-1:0]   c_val;
	logic [mler_pkg::REM_W-1:0]     shifted, hi_ext;
	logic                           ge;
	logic                           fin_go;
	logic                           last_edge;

	assign accept  = item_valid && !item_stall;
	assign cur_t   = (cnt_q == '0) ? item.elem_type : type_q;
	assign cnt_inc = (cnt_q == mler_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign bad_type  = cur_t >= mler_pkg::ET_FIRST_NS;
	assign bad_count = cnt_inc != mler_pkg::TYPE_VERTS[cur_t];
	assign quick     = bad_type || bad_count || (cur_t == mler_pkg::ET_EDGE);

	assign we    = accept && (cnt_q < mler_pkg::CNT_W'(mler_pkg::MAX_VERTICES));
	assign wdata = {
		mler_pkg::STORE_W'(signed'(item.vertex_x[mler_pkg::COORD_WIDTH-1:0])),
		mler_pkg::STORE_W'(signed'(item.vertex_y[mler_pkg::COORD_WIDTH-1:0])),
		mler_pkg::STORE_W'(signed'(item.vertex_z[mler_pkg::COORD_WIDTH-1:0]))};

	mler_ram #(
		.WIDTH (mler_pkg::VERT_W),
		.DEPTH (mler_pkg::MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[mler_pkg::VIDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		logic signed [mler_pkg::STORE_W:0] diff;
		for (int k = 0; k < 3; k++) begin
			diff = {va_q[k*mler_pkg::STORE_W + mler_pkg::STORE_W-1],
				va_q[k*mler_pkg::STORE_W +: mler_pkg::STORE_W]}
				- {rdata[k*mler_pkg::STORE_W + mler_pkg::STORE_W-1],
				rdata[k*mler_pkg::STORE_W +: mler_pkg::STORE_W]};
			if (diff[mler_pkg::STORE_W]) begin
				dcomb[k] = mler_pkg::STORE_W'(-diff);
			end else begin
				dcomb[k] = mler_pkg::STORE_W'(diff);
			end
		end
	end

	assign c_val   = r_q | (mler_pkg::RATIO_W'(1) << bit_q);
	assign mul_a   = (state_q == mler_pkg::S_SQ) ? d_q[k_q] : mler_pkg::STORE_W'(c_val);
	assign mul_res = mul_a * mul_a;

	assign hi_ext  = {1'b0, hi_q};
	assign shifted = (step_q == '0) ? rem_q : {rem_q[mler_pkg::REM_W-2:0], 1'b0};
	assign ge      = shifted >= hi_ext;

	assign fin_go    = !out_valid_q || !result_stall;
	assign last_edge = ecnt_q == mler_pkg::TYPE_EDGES[type_q] - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mler_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		raddr      = mler_pkg::EDGE_A[eidx_q];
		case (state_q)
			mler_pkg::S_IDLE: begin
				item_stall = 1'b0;
				if (accept && item.last_vertex) begin
					state_d = quick ? mler_pkg::S_FIN : mler_pkg::S_RDA;
				end
			end
			mler_pkg::S_RDA:  state_d = mler_pkg::S_RDB;
			mler_pkg::S_RDB: begin
				raddr   = mler_pkg::EDGE_B[eidx_q];
				state_d = mler_pkg::S_DIFF;
			end
			mler_pkg::S_DIFF: state_d = mler_pkg::S_SQ;
			mler_pkg::S_SQ:   state_d = mler_pkg::S_ADD;
			mler_pkg::S_ADD:  state_d = (k_q == 2'd2) ? mler_pkg::S_CMP : mler_pkg::S_SQ;
			mler_pkg::S_CMP:  state_d = last_edge ? mler_pkg::S_HCHK : mler_pkg::S_RDA;
			mler_pkg::S_HCHK: state_d = (hi_q == '0) ? mler_pkg::S_FIN : mler_pkg::S_DIV;
			mler_pkg::S_DIV: begin
				if (step_q == mler_pkg::STEP_W'(mler_pkg::QUOT_W - 1)) begin
					state_d = mler_pkg::S_SQM;
				end
			end
			mler_pkg::S_SQM:  state_d = mler_pkg::S_SQC;
			mler_pkg::S_SQC:  state_d = (bit_q == '0) ? mler_pkg::S_FIN : mler_pkg::S_SQM;
			mler_pkg::S_FIN: begin
				if (fin_go) begin
					state_d = mler_pkg::S_IDLE;
				end
			end
			default: state_d = mler_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			type_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				type_q <= cur_t;
				cnt_q  <= item.last_vertex ? '0 : cnt_inc;
			end
			if (state_q == mler_pkg::S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mler_pkg::S_IDLE: begin
				eidx_q <= mler_pkg::TYPE_FIRST[cur_t];
				ecnt_q <= '0;
				if (bad_type) begin
					res_q.ratio  <= '0;
					res_q.status <= mler_pkg::STS_BAD_TYPE;
				end else if (bad_count) begin
					res_q.ratio  <= '0;
					res_q.status <= mler_pkg::STS_BAD_COUNT;
				end else begin
					res_q.status <= mler_pkg::STS_OK;
					res_q.ratio  <= (cur_t == mler_pkg::ET_EDGE) ? mler_pkg::RATIO_ONE : '0;
				end
			end
			mler_pkg::S_RDB: va_q <= rdata;
			mler_pkg::S_DIFF: begin
				d_q   <= dcomb;
				k_q   <= '0;
				acc_q <= '0;
			end
			mler_pkg::S_SQ: prod_q <= mul_res;
			mler_pkg::S_ADD: begin
				acc_q <= acc_q + mler_pkg::SQ_W'(prod_q);
				k_q   <= k_q + 1'b1;
			end
			mler_pkg::S_CMP: begin
				if (ecnt_q == '0 || acc_q < lo_q) begin
					lo_q <= acc_q;
				end
				if (ecnt_q == '0 || acc_q > hi_q) begin
					hi_q <= acc_q;
				end
				ecnt_q <= ecnt_q + 1'b1;
				eidx_q <= eidx_q + 1'b1;
			end
			mler_pkg::S_HCHK: begin
				rem_q  <= {1'b0, lo_q};
				step_q <= '0;
				quot_q <= '0;
				if (hi_q == '0) begin
					res_q.status <= mler_pkg::STS_ZERO_EDGE;
				end
			end
			mler_pkg::S_DIV: begin
				rem_q  <= ge ? shifted - hi_ext : shifted;
				quot_q <= {quot_q[mler_pkg::QUOT_W-2:0], ge};
				step_q <= step_q + 1'b1;
				r_q    <= '0;
				bit_q  <= mler_pkg::BIT_W'(mler_pkg::RATIO_W - 1);
			end
			mler_pkg::S_SQM: prod_q <= mul_res;
			mler_pkg::S_SQC: begin
				if (prod_q <= mler_pkg::PROD_W'(quot_q)) begin
					r_q         <= c_val;
					res_q.ratio <= c_val;
				end
				bit_q <= bit_q - 1'b1;
			end
			mler_pkg::S_FIN: begin
				if (fin_go) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ASSERT_CLK(a_out_after_fin, $rose(result_valid) |-> $past(state_q) == mler_pkg::S_FIN, "result raised outside the final state")
	`ASSERT_IMPL(a_err_ratio_zero, result_valid && result.status != mler_pkg::STS_OK, result.ratio == '0, "error result carries a ratio")
	`ASSERT_IMPL(a_ratio_range, result_valid, result.ratio <= mler_pkg::RATIO_ONE, "ratio above one")
	`ASSERT_IMPL(a_lo_le_hi, state_q == mler_pkg::S_DIV, lo_q <= hi_q, "shortest edge exceeds longest")

endmodule

// ===== sim/mesh_edge_length_ratio_core_test.sv =====
// Self-checking testbench of mesh_edge_length_ratio_core: it sends mesh element vertices
// under varied idling and checks every ratio and status against its own predictor.
// Depends on mler_pkg and the RTL of mesh_edge_length_ratio_core.
`timescale 1ns / 1ps

module mesh_edge_length_ratio_core_test;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	mler_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	mler_pkg::result_t result;

	mler_pkg::result_t expected_results[$];
	logic signed [31:0] vert_store[8][3];
	int vert_count;
	logic [2:0] elem_kind;
	int errors;
	int cycles;
	int gap_pct;
	int stall_pct;
	int hold_cycles;

	mesh_edge_length_ratio_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [65:0] edge_sq(int p, int q);
		logic [65:0] acc;
		logic signed [32:0] d;
		logic [32:0] ad;
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			d = 33'(vert_store[p][k]) - 33'(vert_store[q][k]);
			ad = (d < 0) ? 33'(-d) : 33'(d);
			acc += 66'(ad) * 66'(ad);
		end
		return acc;
	endfunction

	function automatic mler_pkg::result_t close_element(logic [2:0] kind, int n);
		mler_pkg::result_t res;
		logic [65:0] lo, hi, s;
		logic [127:0] target, c;
		logic [mler_pkg::RATIO_W-1:0] r;
		int first;
		res.ratio = '0;
		res.status = mler_pkg::STS_OK;
		if (kind >= mler_pkg::ET_FIRST_NS) begin
			res.status = mler_pkg::STS_BAD_TYPE;
			return res;
		end
		if (n != int'(mler_pkg::TYPE_VERTS[kind])) begin
			res.status = mler_pkg::STS_BAD_COUNT;
			return res;
		end
		if (kind == mler_pkg::ET_EDGE) begin
			res.ratio = mler_pkg::RATIO_ONE;
			return res;
		end
		first = int'(mler_pkg::TYPE_FIRST[kind]);
		lo = edge_sq(int'(mler_pkg::EDGE_A[first]), int'(mler_pkg::EDGE_B[first]));
		hi = lo;
		for (int i = 1; i < int'(mler_pkg::TYPE_EDGES[kind]); i++) begin
			s = edge_sq(int'(mler_pkg::EDGE_A[first + i]), int'(mler_pkg::EDGE_B[first + i]));
			if (s < lo)
				lo = s;
			if (s > hi)
				hi = s;
		end
		if (hi == 0) begin
			res.status = mler_pkg::STS_ZERO_EDGE;
			return res;
		end
		target = 128'(lo) << (2 * mler_pkg::RATIO_FRAC_BITS);
		r = '0;
		for (int b = mler_pkg::RATIO_FRAC_BITS; b >= 0; b--) begin
			c = 128'(r | (mler_pkg::RATIO_W'(1) << b));
			if (128'(hi) * c * c <= target)
				r = mler_pkg::RATIO_W'(c);
		end
		res.ratio = r;
		return res;
	endfunction

	task automatic predict_vertex(mler_pkg::item_t v);
		if (vert_count == 0)
			elem_kind = v.elem_type;
		if (vert_count < mler_pkg::MAX_VERTICES) begin
			vert_store[vert_count][0] = v.vertex_x;
			vert_store[vert_count][1] = v.vertex_y;
			vert_store[vert_count][2] = v.vertex_z;
		end
		if (vert_count < 15)
			vert_count++;
		if (v.last_vertex) begin
			expected_results = {expected_results, close_element(elem_kind, vert_count)};
			vert_count = 0;
		end
	endtask

	task automatic send_vertex(mler_pkg::item_t v);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_vertex(v);
	endtask

	task automatic send_raw(logic [2:0] kind, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic last);
		mler_pkg::item_t v;
		v.elem_type = kind;
		v.vertex_x = x;
		v.vertex_y = y;
		v.vertex_z = z;
		v.last_vertex = last;
		send_vertex(v);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $signed(32'($urandom_range(8)) << 16) - 32'sh40000;
			1: return $signed($urandom_range(32'h7ffff)) - 32'sh40000;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send_element(logic [2:0] kind, int n, bit tag_noise);
		int mode;
		logic [2:0] tag;
		mode = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			tag = (i > 0 && tag_noise) ? 3'($urandom_range(7)) : kind;
			send_raw(tag, rand_coord(mode), rand_coord(mode), rand_coord(mode),
				i == n - 1);
		end
	endtask

	task automatic random_elements(int items);
		int sent, n, roll;
		logic [2:0] kind;
		sent = 0;
		while (sent < items) begin
			kind = 3'($urandom_range(7));
			roll = $urandom_range(99);
			if (kind >= mler_pkg::ET_FIRST_NS)
				n = $urandom_range(1, 3);
			else if (roll < 80)
				n = int'(mler_pkg::TYPE_VERTS[kind]);
			else
				n = $urandom_range(1, 12);
			send_element(kind, n, $urandom_range(9) == 0);
			sent += n;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		gap_pct = 0;
		stall_pct = 0;
		send_raw(mler_pkg::ET_EDGE, 32'sh7fffffff, 32'sh80000000, 32'sh0, 1'b0);
		send_raw(mler_pkg::ET_EDGE, 32'sh80000000, 32'sh7fffffff, 32'shffffffff, 1'b1);
		send_raw(mler_pkg::ET_TRIANGLE, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
		send_raw(mler_pkg::ET_QUAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
		send_raw(mler_pkg::ET_LAST_NS, 32'sh0, 32'sh10000, 32'sh0, 1'b1);
		send_raw(mler_pkg::ET_FIRST_NS, 32'sh1, 32'sh2, 32'sh3, 1'b1);
		send_raw(mler_pkg::ET_LAST_NS, 32'sh1, 32'sh2, 32'sh3, 1'b1);
		send_raw(mler_pkg::ET_QUAD, 32'sh1, 32'sh2, 32'sh3, 1'b0);
		send_raw(mler_pkg::ET_QUAD, 32'sh1, 32'sh2, 32'sh4, 1'b1);
		for (int i = 0; i < 4; i++)
			send_raw(mler_pkg::ET_TETRA, 32'sh12345, -32'sh777, 32'sh5, i == 3);
		for (int i = 0; i < 10; i++)
			send_raw(mler_pkg::ET_HEX, 32'(i) << 16, 32'sh0, -(32'(i) << 12), i == 9);
		send_element(mler_pkg::ET_PRISM, 6, 1'b0);
		drain();
	endtask

	task automatic test_every_type();
		for (int k = 0; k <= 7; k++)
			send_element(3'(k), (k < 6) ? int'(mler_pkg::TYPE_VERTS[k]) : 1, 1'b0);
		drain();
	endtask

	task automatic test_random_phases();
		int pct[4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{22, 22}};
		for (int p = 0; p < 4; p++) begin
			gap_pct = pct[p][0];
			stall_pct = pct[p][1];
			random_elements(400);
			drain();
		end
	endtask

	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 1500;
		random_elements(150);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		mler_pkg::result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result ratio=%0d status=%0d", result.ratio, result.status);
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (result.ratio !== exp_res.ratio) begin
					$error("ratio expected %0d actual %0d", exp_res.ratio, result.ratio);
					errors++;
				end
				if (result.status !== exp_res.status) begin
					$error("status expected %0d actual %0d", exp_res.status, result.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		vert_count = 0;
		elem_kind = mler_pkg::ET_EDGE;
		gap_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_every_type();
		test_random_phases();
		test_backpressure();
		repeat (400) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mler_pkg.sv
rtl/mler_ram.sv
rtl/mesh_edge_length_ratio_core.sv
sim/mesh_edge_length_ratio_core_test.sv
